// ----- src/pidaw_pkg.sv -----
// ----------------------------------------------------------------------------
// pidaw_pkg
// Shared constants and saturation helpers for the PID controller with
// clamping anti-windup and filtered derivative.
// ----------------------------------------------------------------------------
package pidaw_pkg;

  localparam int CfgIdxWidth = 3;

  localparam logic [CfgIdxWidth-1:0] CFG_GAIN_P   = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_GAIN_I   = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_GAIN_D   = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_LIM_LO   = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CFG_LIM_HI   = 3'd4;
  localparam logic [CfgIdxWidth-1:0] CFG_F_WEIGHT = 3'd5;

  localparam logic [5:0]  MUL_STEPS  = 6'd48;
  localparam logic [5:0]  DIV_STEPS  = 6'd63;
  localparam logic [31:0] MS_PER_S   = 32'd1000;
  localparam logic [16:0] WEIGHT_ONE = 17'd65536;

  localparam logic [0:0] ACT_CLEAR = 1'b1;

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  function automatic logic [47:0] abs48(input logic [47:0] v);
    return v[47] ? (48'd0 - v) : v;
  endfunction

  function automatic logic [31:0] sat32_s(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'h7fff_ffff;
    else if (v < -34'sd2147483648) return 32'h8000_0000;
    else return v[31:0];
  endfunction

  function automatic logic [47:0] sat48_s(input logic signed [51:0] v);
    if (v > 52'sh0_7fff_ffff_ffff) return 48'h7fff_ffff_ffff;
    else if (v < -52'sh0_8000_0000_0000) return 48'h8000_0000_0000;
    else return v[47:0];
  endfunction

  function automatic logic [31:0] sat32_mag(input logic neg, input logic [80:0] mag);
    if (!neg) return (mag > 81'h7fff_ffff) ? 32'h7fff_ffff : mag[31:0];
    else return (mag > 81'h8000_0000) ? 32'h8000_0000 : (32'd0 - mag[31:0]);
  endfunction

  function automatic logic [47:0] sat48_mag(input logic neg, input logic [62:0] mag);
    if (!neg) return (mag > 63'h7fff_ffff_ffff) ? 48'h7fff_ffff_ffff : mag[47:0];
    else return (mag > 63'h8000_0000_0000) ? 48'h8000_0000_0000 : (48'd0 - mag[47:0]);
  endfunction

endpackage

// ----- src/pid_antiwindup_filtered_d.sv -----
// ----------------------------------------------------------------------------
// pid_antiwindup_filtered_d
// PID step with clamping anti-windup and low-pass filtered derivative,
// built on one shift-add multiplier and one restoring divider, one bit a cycle.
// ----------------------------------------------------------------------------
// A clear item's result is presented in the cycle after accept. A compute item
// runs four 48-step multiplies and one 63-step divide; when the integral is
// updated, six multiplies and two divides, or one divide if the increment saturates.
// Throughput: one item at a time; the next item is taken once the result
// register is free. Reset clears state and sets the registers to defaults.
module pid_antiwindup_filtered_d (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [95:0]                       s_axis_tdata_i,  // target, measurement, time_ms
  input  logic [0:0]                        s_axis_tuser_i,  // action
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [31:0]                       m_axis_tdata_o,  // drive
  output logic [1:0]                        m_axis_tuser_o,  // clamped, integral_held
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pidaw_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic [31:0]                       cfg_data_i
);
  import pidaw_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREP  = 4'd1;
  localparam logic [3:0] S_DIVR  = 4'd2;
  localparam logic [3:0] S_FLOAD = 4'd3;
  localparam logic [3:0] S_MULF  = 4'd4;
  localparam logic [3:0] S_MULP  = 4'd5;
  localparam logic [3:0] S_MULD  = 4'd6;
  localparam logic [3:0] S_MULI  = 4'd7;
  localparam logic [3:0] S_TRIAL = 4'd8;
  localparam logic [3:0] S_MULE  = 4'd9;
  localparam logic [3:0] S_DIVE  = 4'd10;
  localparam logic [3:0] S_UPD   = 4'd11;
  localparam logic [3:0] S_ILOAD = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;

  logic [3:0]  state_q;
  logic [31:0] kp_q, ki_q, kd_q, lim_lo_q, lim_hi_q;
  logic [16:0] weight_q;
  logic [31:0] last_err_q, last_time_q;
  logic [47:0] integ_q, slope_q;

  logic [31:0] err_q, dt_q, now_q;
  logic [47:0] raw_q, inc_q;
  logic [31:0] p_q, i_q, d_q;
  logic        held_q, pass2_q, sneg_q;
  logic [5:0]  cnt_q;

  logic [48:0] mcand_q;
  logic [96:0] prod_q;
  logic [62:0] dq_q;
  logic [31:0] rem_q, dvs_q;

  logic        m_valid_q, o_clamped_q, o_held_q;
  logic [31:0] o_drive_q;

  logic        out_free, in_fire, out_load;
  logic [31:0] in_target, in_meas, in_time, meas_abs;
  logic signed [32:0] err_wide;
  logic [31:0] err_new;
  logic [49:0] mul_sum;
  logic [96:0] mul_next;
  logic [80:0] prod_sh;
  logic [32:0] div_r;
  logic        div_ge;
  logic [31:0] div_rem_next;
  logic signed [32:0] delta;
  logic [32:0] dmag;
  logic signed [51:0] diff, slope_ext, fm_signed;
  logic [51:0] diff_mag;
  logic [16:0] w_eff;
  logic signed [33:0] sum3;
  logic [31:0] sum_sat;
  logic        trial_hi, trial_lo, err_pos, err_neg, held_now;
  logic [31:0] drive_hi;

  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE) && out_free;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load        = (in_fire && (s_axis_tuser_i == ACT_CLEAR)) ||
                           ((state_q == S_FIN) && out_free);
  assign cfg_ready_o     = 1'b1;

  assign in_target = s_axis_tdata_i[31:0];
  assign in_meas   = s_axis_tdata_i[63:32];
  assign in_time   = s_axis_tdata_i[95:64];
  assign meas_abs  = (in_meas == 32'h8000_0000) ? 32'h7fff_ffff : abs32(in_meas);
  assign err_wide  = $signed({in_target[31], in_target}) - $signed({1'b0, meas_abs});
  assign err_new   = sat32_s({err_wide[32], err_wide});

  assign mul_sum  = {1'b0, prod_q[96:48]} + (prod_q[0] ? {1'b0, mcand_q} : 50'd0);
  assign mul_next = {mul_sum, prod_q[47:1]};
  assign prod_sh  = prod_q[96:16];

  assign div_r        = {rem_q, dq_q[62]};
  assign div_ge       = div_r >= {1'b0, dvs_q};
  assign div_rem_next = div_ge ? 32'(div_r - {1'b0, dvs_q}) : div_r[31:0];

  assign delta = $signed({err_q[31], err_q}) - $signed({last_err_q[31], last_err_q});
  assign dmag  = delta[32] ? (33'd0 - delta) : delta;

  assign slope_ext = $signed({{4{slope_q[47]}}, slope_q});
  assign diff      = $signed({{4{raw_q[47]}}, raw_q}) - slope_ext;
  assign diff_mag  = diff[51] ? (52'd0 - diff) : diff;
  assign w_eff     = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;
  assign fm_signed = sneg_q ? $signed(52'd0 - {2'b0, prod_sh[49:0]})
                            : $signed({2'b0, prod_sh[49:0]});

  assign sum3    = $signed({{2{p_q[31]}}, p_q}) + $signed({{2{i_q[31]}}, i_q})
                 + $signed({{2{d_q[31]}}, d_q});
  assign sum_sat = sat32_s(sum3);
  assign trial_hi = $signed(sum_sat) > $signed(lim_hi_q);
  assign trial_lo = $signed(sum_sat) < $signed(lim_lo_q);
  assign err_pos  = !err_q[31] && (err_q != 32'd0);
  assign err_neg  = err_q[31];
  assign held_now = (trial_hi || trial_lo) &&
                    ((err_pos && !sum_sat[31] && sum_sat != 32'd0) ||
                     (err_neg && sum_sat[31]));
  assign drive_hi = trial_hi ? lim_hi_q : sum_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kp_q        <= '0;
      ki_q        <= '0;
      kd_q        <= '0;
      lim_lo_q    <= 32'h8000_0000;
      lim_hi_q    <= 32'h7fff_ffff;
      weight_q    <= '0;
      last_err_q  <= '0;
      last_time_q <= '0;
      integ_q     <= '0;
      slope_q     <= '0;
      err_q       <= '0;
      dt_q        <= '0;
      now_q       <= '0;
      raw_q       <= '0;
      inc_q       <= '0;
      p_q         <= '0;
      i_q         <= '0;
      d_q         <= '0;
      held_q      <= 1'b0;
      sneg_q      <= 1'b0;
      mcand_q     <= '0;
      prod_q      <= '0;
      dq_q        <= '0;
      rem_q       <= '0;
      dvs_q       <= '0;
      o_drive_q   <= '0;
      o_clamped_q <= 1'b0;
      o_held_q    <= 1'b0;
      m_valid_q   <= 1'b0;
      pass2_q     <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_GAIN_P:   kp_q     <= cfg_data_i;
          CFG_GAIN_I:   ki_q     <= cfg_data_i;
          CFG_GAIN_D:   kd_q     <= cfg_data_i;
          CFG_LIM_LO:   lim_lo_q <= cfg_data_i;
          CFG_LIM_HI:   lim_hi_q <= cfg_data_i;
          CFG_F_WEIGHT: weight_q <= cfg_data_i[16:0];
          default: ;
        endcase
      end

      if (out_load) m_valid_q <= 1'b1;
      else if (m_axis_tready_i) m_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (s_axis_tuser_i == ACT_CLEAR) begin
              last_err_q  <= '0;
              integ_q     <= '0;
              slope_q     <= '0;
              o_drive_q   <= '0;
              o_clamped_q <= 1'b0;
              o_held_q    <= 1'b0;
            end else begin
              err_q   <= err_new;
              dt_q    <= in_time - last_time_q;
              now_q   <= in_time;
              pass2_q <= 1'b0;
              state_q <= S_PREP;
            end
          end
        end
        S_PREP: begin
          dq_q    <= {30'd0, dmag} * 63'(MS_PER_S);
          rem_q   <= '0;
          dvs_q   <= dt_q;
          sneg_q  <= delta[32];
          cnt_q   <= DIV_STEPS;
          state_q <= S_DIVR;
        end
        S_DIVR: begin
          if (cnt_q != 6'd0) begin
            rem_q <= div_rem_next;
            dq_q  <= {dq_q[61:0], div_ge};
            cnt_q <= cnt_q - 6'd1;
          end else begin
            raw_q   <= (dt_q == 32'd0) ? 48'd0 : sat48_mag(sneg_q, dq_q);
            state_q <= S_FLOAD;
          end
        end
        S_FLOAD: begin
          mcand_q <= diff_mag[48:0];
          prod_q  <= {49'd0, 31'd0, w_eff};
          sneg_q  <= diff[51];
          cnt_q   <= MUL_STEPS;
          state_q <= S_MULF;
        end
        S_MULF: begin
          if (cnt_q != 6'd0) begin
            prod_q <= mul_next;
            cnt_q  <= cnt_q - 6'd1;
          end else begin
            slope_q <= sat48_s(slope_ext + fm_signed);
            mcand_q <= {17'd0, abs32(kp_q)};
            prod_q  <= {49'd0, 16'd0, abs32(err_q)};
            sneg_q  <= kp_q[31] ^ err_q[31];
            cnt_q   <= MUL_STEPS;
            state_q <= S_MULP;
          end
        end
        S_MULP: begin
          if (cnt_q != 6'd0) begin
            prod_q <= mul_next;
            cnt_q  <= cnt_q - 6'd1;
          end else begin
            p_q     <= sat32_mag(sneg_q, prod_sh);
            mcand_q <= {17'd0, abs32(kd_q)};
            prod_q  <= {49'd0, abs48(slope_q)};
            sneg_q  <= kd_q[31] ^ slope_q[47];
            cnt_q   <= MUL_STEPS;
            state_q <= S_MULD;
          end
        end
        S_MULD: begin
          if (cnt_q != 6'd0) begin
            prod_q <= mul_next;
            cnt_q  <= cnt_q - 6'd1;
          end else begin
            d_q     <= sat32_mag(sneg_q, prod_sh);
            state_q <= S_ILOAD;
          end
        end
        S_ILOAD: begin
          mcand_q <= {17'd0, abs32(ki_q)};
          prod_q  <= {49'd0, abs48(integ_q)};
          sneg_q  <= ki_q[31] ^ integ_q[47];
          cnt_q   <= MUL_STEPS;
          state_q <= S_MULI;
        end
        S_MULI: begin
          if (cnt_q != 6'd0) begin
            prod_q <= mul_next;
            cnt_q  <= cnt_q - 6'd1;
          end else begin
            i_q     <= sat32_mag(sneg_q, prod_sh);
            state_q <= pass2_q ? S_FIN : S_TRIAL;
          end
        end
        S_TRIAL: begin
          held_q <= held_now;
          if (!held_now && err_q != 32'd0 && dt_q != 32'd0) begin
            mcand_q <= {17'd0, abs32(err_q)};
            prod_q  <= {49'd0, 16'd0, dt_q};
            sneg_q  <= err_q[31];
            cnt_q   <= MUL_STEPS;
            state_q <= S_MULE;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_MULE: begin
          if (cnt_q != 6'd0) begin
            prod_q <= mul_next;
            cnt_q  <= cnt_q - 6'd1;
          end else if (prod_q[62]) begin
            inc_q   <= sneg_q ? 48'h8000_0000_0000 : 48'h7fff_ffff_ffff;
            state_q <= S_UPD;
          end else begin
            dq_q    <= prod_q[62:0];
            rem_q   <= '0;
            dvs_q   <= MS_PER_S;
            cnt_q   <= DIV_STEPS;
            state_q <= S_DIVE;
          end
        end
        S_DIVE: begin
          if (cnt_q != 6'd0) begin
            rem_q <= div_rem_next;
            dq_q  <= {dq_q[61:0], div_ge};
            cnt_q <= cnt_q - 6'd1;
          end else begin
            inc_q   <= sat48_mag(sneg_q, dq_q);
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          integ_q <= sat48_s($signed({{4{integ_q[47]}}, integ_q}) +
                             $signed({{4{inc_q[47]}}, inc_q}));
          pass2_q <= 1'b1;
          state_q <= S_ILOAD;
        end
        S_FIN: begin
          if (out_free) begin
            o_drive_q   <= ($signed(drive_hi) < $signed(lim_lo_q)) ? lim_lo_q : drive_hi;
            o_clamped_q <= trial_hi || ($signed(drive_hi) < $signed(lim_lo_q));
            o_held_q    <= held_q;
            last_err_q  <= err_q;
            last_time_q <= now_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = o_drive_q;
  assign m_axis_tuser_o  = {o_held_q, o_clamped_q};

endmodule
